// ===== sv/ils_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types, codes and widths for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int OP_W         = 4;
  localparam int POS_W        = 9;
  localparam int WORD_W       = 32;
  localparam int STAT_W       = 2;
  localparam int LEN_W        = 9;
  localparam int DEF_CAPACITY = 256;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_BACK   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_INSERT     = 4'd4,
    OP_ERASE      = 4'd5,
    OP_REMOVE     = 4'd6,
    OP_CLEAR      = 4'd7,
    OP_READ       = 4'd8,
    OP_WRITE      = 4'd9,
    OP_MAX        = 4'd10,
    OP_MIN        = 4'd11
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_UP,
    S_DOWN,
    S_REMOVE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    state_t phase;
    op_t    op;
    logic   load;
    logic   load_out;
  } ils_cmd_t;

  typedef struct packed {
    status_t chk;
    logic    walk_done;
  } ils_stat_t;

endpackage
`default_nettype wire

// ===== sv/ils_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_if
// Request and response channels of the indexed list store.
// ----------------------------------------------------------------------------
interface ils_req_if
  import ils_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] data_word;

  modport source (output valid, operation, position, data_word, input ready);
  modport sink   (input valid, operation, position, data_word, output ready);
endinterface

interface ils_rsp_if
  import ils_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] result_word;
  logic [LEN_W-1:0]         new_length;
  logic [LEN_W-1:0]         removed_count;

  modport source (output valid, status, result_word, new_length, removed_count,
                  input ready);
  modport sink   (input valid, status, result_word, new_length, removed_count,
                  output ready);
endinterface
`default_nettype wire

// ===== sv/ils_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_datapath
// Entry memory, length, walk pointers, checks and the response register.
// ----------------------------------------------------------------------------
module ils_datapath
  import ils_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ils_cmd_t                 cmd,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] data_word,
  output ils_stat_t                stat,
  output logic [STAT_W-1:0]        status,
  output logic signed [WORD_W-1:0] result_word,
  output logic [LEN_W-1:0]         new_length,
  output logic [LEN_W-1:0]         removed_count
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int PW     = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rdata;

  logic [PW-1:0]     pos_r;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  gpos;
  logic [CNT_W-1:0]  wptr;
  logic [CNT_W-1:0]  paddr;
  logic              pv;
  logic [WORD_W-1:0] acc;
  logic [CNT_W-1:0]  removed;
  status_t           status_r;

  logic [PW-1:0]     count_ext;
  logic [PW-1:0]     eff;
  logic [CNT_W-1:0]  eff_c;
  status_t           chk;
  logic              issue;
  logic              done;
  logic [CNT_W-1:0]  ra;
  logic              we;
  logic [CNT_W-1:0]  wa;
  logic [WORD_W-1:0] wd;
  logic              better;

  assign count_ext = PW'(count);

  always_comb begin
    case (cmd.op)
      OP_PUSH_BACK:  eff = count_ext;
      OP_PUSH_FRONT: eff = '0;
      OP_POP_FRONT:  eff = '0;
      OP_POP_BACK:   eff = count_ext - PW'(1);
      default:       eff = pos_r;
    endcase
  end

  assign eff_c = eff[CNT_W-1:0];

  always_comb begin
    case (cmd.op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          chk = ST_FULL;
        end else if (eff > count_ext) begin
          chk = ST_RANGE;
        end else begin
          chk = ST_OK;
        end
      end
      OP_POP_BACK, OP_POP_FRONT, OP_ERASE, OP_READ, OP_WRITE: begin
        if (count == '0) begin
          chk = ST_EMPTY;
        end else if (eff >= count_ext) begin
          chk = ST_RANGE;
        end else begin
          chk = ST_OK;
        end
      end
      OP_REMOVE, OP_MAX, OP_MIN: begin
        chk = (count == '0) ? ST_EMPTY : ST_OK;
      end
      default: chk = ST_OK;
    endcase
  end

  assign issue = (cmd.phase == S_UP) ? (idx > gpos) : (idx < count);
  assign done  = !issue && !pv;

  assign stat.chk       = chk;
  assign stat.walk_done = done;

  always_comb begin
    case (cmd.phase)
      S_CHECK: ra = eff_c;
      S_UP:    ra = idx - CNT_W'(1);
      default: ra = idx;
    endcase
  end

  // Max or min: a later entry replaces the running value only when strictly beyond it
  assign better = (cmd.op == OP_MAX) ? ($signed(rdata) > $signed(acc))
                                     : ($signed(acc) > $signed(rdata));

  always_comb begin
    we = 1'b0;
    wa = idx;
    wd = rdata;
    case (cmd.phase)
      S_CHECK: begin
        if (cmd.op == OP_WRITE && chk == ST_OK) begin
          we = 1'b1;
          wa = eff_c;
          wd = word_r;
        end
      end
      S_UP: begin
        if (pv) begin
          we = 1'b1;
          wa = paddr + CNT_W'(1);
        end else if (done) begin
          we = 1'b1;
          wa = gpos;
          wd = word_r;
        end
      end
      S_DOWN: begin
        if (pv) begin
          we = 1'b1;
          wa = paddr - CNT_W'(1);
        end
      end
      S_REMOVE: begin
        if (pv && rdata != word_r) begin
          we = 1'b1;
          wa = wptr;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa[ADDR_W-1:0]] <= wd;
    end
    rdata <= mem[ra[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pv    <= 1'b0;
    end else begin
      case (cmd.phase)
        S_IDLE: begin
          if (cmd.load) begin
            pos_r  <= PW'(position);
            word_r <= data_word;
          end
        end
        S_CHECK: begin
          status_r <= chk;
          acc      <= '0;
          removed  <= '0;
          pv       <= 1'b0;
          wptr     <= '0;
          gpos     <= eff_c;
          case (cmd.op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: idx <= count;
            OP_POP_BACK, OP_POP_FRONT, OP_ERASE:    idx <= eff_c + CNT_W'(1);
            default:                                idx <= '0;
          endcase
          if (cmd.op == OP_CLEAR) begin
            count <= '0;
          end
        end
        S_UP: begin
          pv <= issue;
          if (issue) begin
            idx   <= idx - CNT_W'(1);
            paddr <= idx - CNT_W'(1);
          end
          if (done) begin
            count <= count + CNT_W'(1);
          end
        end
        S_DOWN, S_REMOVE, S_SCAN: begin
          pv <= issue;
          if (issue) begin
            idx   <= idx + CNT_W'(1);
            paddr <= idx;
          end
          if (cmd.phase == S_DOWN && done) begin
            count <= count - CNT_W'(1);
          end
          if (cmd.phase == S_REMOVE) begin
            if (pv) begin
              if (rdata == word_r) begin
                removed <= removed + CNT_W'(1);
              end else begin
                wptr <= wptr + CNT_W'(1);
              end
            end
            if (done) begin
              count <= wptr;
            end
          end
          if (cmd.phase == S_SCAN && pv) begin
            if (paddr == '0 || better) begin
              acc <= rdata;
            end
          end
        end
        S_READ: acc <= rdata;
        default: pv <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status        <= status_r;
      result_word   <= acc;
      new_length    <= LEN_W'(count);
      removed_count <= LEN_W'(removed);
    end
  end

endmodule
`default_nettype wire

// ===== sv/ils_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ils_ctrl
// Request sequencer: check, walk over the entries, post the response.
// ----------------------------------------------------------------------------
module ils_ctrl
  import ils_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] operation,
  output logic            out_valid,
  input  logic            out_ready,
  input  ils_stat_t       stat,
  output ils_cmd_t        cmd
);

  state_t state;
  state_t state_next;
  op_t    op_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r <= op_t'(operation);
    end
  end

  always_comb begin
    state_next   = state;
    cmd.phase    = state;
    cmd.op       = op_r;
    cmd.load     = 1'b0;
    cmd.load_out = 1'b0;
    in_ready     = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.chk != ST_OK) begin
          state_next = S_FINISH;
        end else begin
          case (op_r)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: state_next = S_UP;
            OP_POP_BACK, OP_POP_FRONT, OP_ERASE:    state_next = S_DOWN;
            OP_REMOVE:                              state_next = S_REMOVE;
            OP_MAX, OP_MIN:                         state_next = S_SCAN;
            OP_READ:                                state_next = S_READ;
            default:                                state_next = S_FINISH;
          endcase
        end
      end
      S_UP, S_DOWN, S_REMOVE, S_SCAN: begin
        if (stat.walk_done) begin
          state_next = S_FINISH;
        end
      end
      S_READ: state_next = S_FINISH;
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/indexed_list_store_core.sv =====
`default_nettype none
// Clear, write, spare codes and any rejected request go from check straight to
// finish; read passes through the read state; the other codes walk the entries,
// which the walk reads one per cycle, and then finish.
// Throughput: one request at a time, accepted again from the cycle in which
// the response is posted.
// Reset clears length, state and response valid; memory is not cleared, no pass.
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed words with push, pop, insert, erase, remove by
// value, clear, read, write, maximum and minimum.
// ----------------------------------------------------------------------------
module indexed_list_store_core
  import ils_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  ils_cmd_t  cmd;
  ils_stat_t stat;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .operation (req.operation),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .position      (req.position),
    .data_word     (req.data_word),
    .stat          (stat),
    .status        (rsp.status),
    .result_word   (rsp.result_word),
    .new_length    (rsp.new_length),
    .removed_count (rsp.removed_count)
  );

endmodule
`default_nettype wire
